// ===== rtl/kri_pkg.sv =====
// ----------------------------------------------------------------------------
// kri_pkg: shared types and constants of the reduction tree index unit
// Field widths, status and register codes, and the divider request/response.
// ----------------------------------------------------------------------------
package kri_pkg;

   localparam int ID_W    = 21;
   localparam int START_W = 22;
   localparam int FAN_W   = 7;
   localparam int LVL_W   = 5;
   localparam int CSR_W   = 1;

   localparam logic [20:0] LEAF_MAX = 21'd1048576;

   localparam logic [1:0] STATUS_VALID = 2'd0;
   localparam logic [1:0] STATUS_NONE  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_LEAF_COUNT = 1'd0;
   localparam logic [CSR_W-1:0] CSR_FAN_IN     = 1'd1;

   typedef struct packed {
      logic            go;
      logic [ID_W-1:0] dividend;
      logic [FAN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [ID_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/kri_serial_div.sv =====
// ----------------------------------------------------------------------------
// kri_serial_div: bit-serial restoring divider
// Divides a node count or offset by the fan-in, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kri_serial_div (
   input  logic                 clock,
   input  logic                 reset,
   input  kri_pkg::div_req_type req,
   output kri_pkg::div_rsp_type rsp
);
   import kri_pkg::*;

   localparam int CNT_W = $clog2(ID_W);

   logic [ID_W-1:0]  quo_ff;
   logic [FAN_W-1:0] rem_ff;
   logic [FAN_W-1:0] div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   logic [FAN_W:0]   trial;
   logic             take;
   logic [FAN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[ID_W-1]};
      take   = trial >= {1'b0, div_ff};
      rem_in = take ? FAN_W'(trial - {1'b0, div_ff}) : trial[FAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            quo_ff <= req.dividend;
            div_ff <= req.divisor;
            rem_ff <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            quo_ff <= {quo_ff[ID_W-2:0], take};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ID_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/kary_reduction_tree_index.sv =====
// ----------------------------------------------------------------------------
// kary_reduction_tree_index: parent and child ids of a k-ary reduction tree
// Builds per-level size and start tables from the leaf count and fan-in,
// then answers parent or children queries for a global node id.
// ----------------------------------------------------------------------------
// Usage:
// An item (req_kind, req_node_id) is taken at a clock edge with start high
// and busy low. Results appear on the rsp_ ports for one cycle each, marked
// by rsp_strobe; rsp_last marks the final one. The receiver cannot stall.
// A csr_write_en pulse writes leaf_count (index 0) or fan_in (index 1) and
// starts a table rebuild; busy stays high until it ends. A rebuild stores
// the size and start of each level in S_BUILD_STORE, and between levels
// the bit-serial divider (one quotient bit per cycle) gives the next size
// in S_BUILD_DIV. Reset loads one leaf and fan-in 2 and rebuilds. A query
// first checks the id in S_CHECK and answers STATUS_RANGE for an id beyond
// the tree; otherwise S_SEARCH finds the level of the node. A missing
// relative is answered from S_OFFSET, or from S_BOUND for an empty child
// range; a parent comes from S_PARENT after the divider. Children take the
// serial multiply (S_MUL) and bound (S_BOUND), then one per cycle in S_EMIT.
// The block works on one item at a time.
// ----------------------------------------------------------------------------
module kary_reduction_tree_index #(
   parameter int MAX_LEVELS = 21,
   parameter int MAX_FAN_IN = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [kri_pkg::ID_W-1:0]    req_node_id,
   output logic                        rsp_strobe,
   output logic [kri_pkg::ID_W-1:0]    rsp_result_id,
   output logic [1:0]                  rsp_status,
   output logic [kri_pkg::LVL_W-1:0]   rsp_node_level,
   output logic                        rsp_last,
   input  logic                        csr_write_en,
   input  logic [kri_pkg::CSR_W-1:0]   csr_index,
   input  logic [kri_pkg::ID_W-1:0]    csr_wdata
);
   import kri_pkg::*;

   localparam int LW     = $clog2(MAX_LEVELS + 1);
   localparam int SW     = $clog2(MAX_LEVELS);
   localparam int MCNT_W = $clog2(FAN_W);

   typedef enum logic [3:0] {
      S_BUILD_INIT, S_BUILD_STORE, S_BUILD_DIV, S_IDLE, S_CHECK, S_SEARCH,
      S_OFFSET, S_PARENT, S_MUL, S_BOUND, S_EMIT
   } state_type;

   state_type          state_ff;
   logic [ID_W-1:0]    leaf_ff;
   logic [FAN_W-1:0]   fan_ff;
   logic [FAN_W-1:0]   eff_fan_ff;
   logic [ID_W-1:0]    size_ff;
   logic [START_W-1:0] acc_start_ff;
   logic [LW-1:0]      n_ff;
   logic [LW-1:0]      total_ff;
   logic [ID_W-1:0]    level_size_ff [MAX_LEVELS];
   logic [START_W-1:0] level_start_ff [MAX_LEVELS+1];
   logic               kind_ff;
   logic [ID_W-1:0]    id_ff;
   logic [LW-1:0]      lvl_ff;
   logic [ID_W-1:0]    mul_k_ff;
   logic [FAN_W-1:0]   mul_fan_ff;
   logic [MCNT_W-1:0]  mul_cnt_ff;
   logic [ID_W-1:0]    lo_ff;
   logic [ID_W-1:0]    hi_ff;
   logic               rsp_strobe_ff;
   logic [ID_W-1:0]    rsp_result_id_ff;
   logic [1:0]         rsp_status_ff;
   logic [LVL_W-1:0]   rsp_node_level_ff;
   logic               rsp_last_ff;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [ID_W-1:0]    leaf_sat;
   logic [FAN_W-1:0]   fan_sat;
   logic [LW-1:0]      lvl_p1;
   logic [LW-1:0]      lvl_m1;
   logic [LW-1:0]      start_addr;
   logic [START_W-1:0] start_rd;
   logic [ID_W-1:0]    size_rd;
   logic [START_W-1:0] acc_start_in;
   logic               build_last;
   logic [ID_W-1:0]    k_in;
   logic               parent_none;
   logic [START_W-1:0] bound_sum;
   logic [ID_W-1:0]    hi_in;
   logic               emit_last;

   kri_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      if (leaf_ff == '0) begin
         leaf_sat = ID_W'(1);
      end else if (leaf_ff > LEAF_MAX) begin
         leaf_sat = LEAF_MAX;
      end else begin
         leaf_sat = leaf_ff;
      end
      if (fan_ff < FAN_W'(2)) begin
         fan_sat = FAN_W'(2);
      end else if (fan_ff > FAN_W'(MAX_FAN_IN)) begin
         fan_sat = FAN_W'(MAX_FAN_IN);
      end else begin
         fan_sat = fan_ff;
      end

      lvl_p1 = lvl_ff + LW'(1);
      lvl_m1 = lvl_ff - LW'(1);
      unique case (state_ff)
         S_CHECK:            start_addr = total_ff;
         S_SEARCH, S_PARENT: start_addr = lvl_p1;
         S_OFFSET:           start_addr = lvl_ff;
         default:            start_addr = lvl_m1;
      endcase
      start_rd = level_start_ff[start_addr];
      size_rd  = level_size_ff[lvl_m1[SW-1:0]];

      acc_start_in = acc_start_ff + START_W'(size_ff);
      build_last   = (size_ff <= ID_W'(1)) || (n_ff == LW'(MAX_LEVELS - 1));
      k_in         = ID_W'({1'b0, id_ff} - start_rd);
      parent_none  = !(lvl_p1 < total_ff);

      bound_sum = START_W'(lo_ff) + START_W'(eff_fan_ff);
      hi_in     = (bound_sum > START_W'(size_rd)) ? size_rd : ID_W'(bound_sum);
      emit_last = ID_W'(lo_ff + ID_W'(1)) == hi_ff;

      div_req.go       = 1'b0;
      div_req.dividend = k_in;
      div_req.divisor  = eff_fan_ff;
      if (state_ff == S_BUILD_STORE) begin
         div_req.go       = !build_last;
         div_req.dividend = size_ff + ID_W'(eff_fan_ff) - ID_W'(1);
      end else if (state_ff == S_OFFSET) begin
         div_req.go = !kind_ff && !parent_none;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_BUILD_INIT;
         leaf_ff       <= ID_W'(1);
         fan_ff        <= FAN_W'(2);
         rsp_strobe_ff <= 1'b0;
      end else if (csr_write_en) begin
         rsp_strobe_ff <= 1'b0;
         if (csr_index == CSR_LEAF_COUNT) begin
            leaf_ff <= csr_wdata;
         end else begin
            fan_ff <= csr_wdata[FAN_W-1:0];
         end
         state_ff <= S_BUILD_INIT;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_BUILD_INIT: begin
               size_ff           <= leaf_sat;
               eff_fan_ff        <= fan_sat;
               n_ff              <= '0;
               acc_start_ff      <= '0;
               level_start_ff[0] <= '0;
               state_ff          <= S_BUILD_STORE;
            end
            S_BUILD_STORE: begin
               level_size_ff[n_ff[SW-1:0]]  <= size_ff;
               level_start_ff[n_ff + LW'(1)] <= acc_start_in;
               acc_start_ff                  <= acc_start_in;
               n_ff                          <= n_ff + LW'(1);
               if (build_last) begin
                  total_ff <= n_ff + LW'(1);
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_BUILD_DIV;
               end
            end
            S_BUILD_DIV: begin
               if (div_rsp.done) begin
                  size_ff  <= div_rsp.quotient;
                  state_ff <= S_BUILD_STORE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  kind_ff  <= req_kind;
                  id_ff    <= req_node_id;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               lvl_ff <= '0;
               if ({1'b0, id_ff} >= start_rd) begin
                  rsp_strobe_ff     <= 1'b1;
                  rsp_result_id_ff  <= '0;
                  rsp_status_ff     <= STATUS_RANGE;
                  rsp_node_level_ff <= '0;
                  rsp_last_ff       <= 1'b1;
                  state_ff          <= S_IDLE;
               end else begin
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (lvl_p1 < total_ff && {1'b0, id_ff} >= start_rd) begin
                  lvl_ff <= lvl_p1;
               end else begin
                  state_ff <= S_OFFSET;
               end
            end
            S_OFFSET: begin
               mul_k_ff          <= k_in;
               mul_fan_ff        <= eff_fan_ff;
               mul_cnt_ff        <= '0;
               lo_ff             <= '0;
               rsp_node_level_ff <= LVL_W'(lvl_ff);
               if (!kind_ff) begin
                  if (parent_none) begin
                     rsp_strobe_ff    <= 1'b1;
                     rsp_result_id_ff <= '0;
                     rsp_status_ff    <= STATUS_NONE;
                     rsp_last_ff      <= 1'b1;
                     state_ff         <= S_IDLE;
                  end else begin
                     state_ff <= S_PARENT;
                  end
               end else if (lvl_ff == '0) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_result_id_ff <= '0;
                  rsp_status_ff    <= STATUS_NONE;
                  rsp_last_ff      <= 1'b1;
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_PARENT: begin
               if (div_rsp.done) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_result_id_ff <= ID_W'(start_rd + START_W'(div_rsp.quotient));
                  rsp_status_ff    <= STATUS_VALID;
                  rsp_last_ff      <= 1'b1;
                  state_ff         <= S_IDLE;
               end
            end
            S_MUL: begin
               if (mul_fan_ff[0]) begin
                  lo_ff <= lo_ff + mul_k_ff;
               end
               mul_k_ff   <= {mul_k_ff[ID_W-2:0], 1'b0};
               mul_fan_ff <= {1'b0, mul_fan_ff[FAN_W-1:1]};
               mul_cnt_ff <= mul_cnt_ff + MCNT_W'(1);
               if (mul_cnt_ff == MCNT_W'(FAN_W - 1)) begin
                  state_ff <= S_BOUND;
               end
            end
            S_BOUND: begin
               hi_ff <= hi_in;
               if (lo_ff >= hi_in) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_result_id_ff <= '0;
                  rsp_status_ff    <= STATUS_NONE;
                  rsp_last_ff      <= 1'b1;
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_result_id_ff <= ID_W'(start_rd + START_W'(lo_ff));
               rsp_status_ff    <= STATUS_VALID;
               rsp_last_ff      <= emit_last;
               lo_ff            <= lo_ff + ID_W'(1);
               if (emit_last) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_BUILD_INIT;
            end
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE) || csr_write_en;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_result_id  = rsp_result_id_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node_level = rsp_node_level_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== tb/sv/kary_reduction_tree_index_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kary_reduction_tree_index_test: self-checking bench for the tree index unit
// Programs leaf counts and fan-ins, including saturated ones, and walks a
// directed table of parent and children queries. Random phases follow. A
// local model of the level tables predicts the result items that directed
// rows do not give; each is compared in order as it is strobed out.
// ----------------------------------------------------------------------------
module kary_reduction_tree_index_test;

   import kri_pkg::*;

   localparam int PERIOD      = 20;
   localparam int TREE_LEVELS = 21;
   localparam int FAN_LIMIT   = 64;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 28;
   localparam int END_WAIT    = 64;
   localparam int WATCHDOG    = 20000;

   localparam logic KIND_PARENT   = 1'b0;
   localparam logic KIND_CHILDREN = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [1:0]       status;
      logic [LVL_W-1:0] level;
      logic             last;
   } relative_type;

   typedef enum logic [1:0] {ROW_QUERY, ROW_LEAF, ROW_FAN} row_op_type;

   typedef struct {
      row_op_type       op;
      logic             kind;
      logic [ID_W-1:0]  value;
      bit               typed;
      logic [1:0]       status;
      logic [LVL_W-1:0] level;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_kind = 1'b0;
   logic [ID_W-1:0]     req_node_id = '0;
   logic                rsp_strobe;
   logic [ID_W-1:0]     rsp_result_id;
   logic [1:0]          rsp_status;
   logic [LVL_W-1:0]    rsp_node_level;
   logic                rsp_last;
   logic                csr_write_en = 1'b0;
   logic [CSR_W-1:0]    csr_index = '0;
   logic [ID_W-1:0]     csr_wdata = '0;

   logic [ID_W-1:0]     cfg_leaf;
   logic [FAN_W-1:0]    cfg_fan;
   logic [ID_W-1:0]     lvl_size [TREE_LEVELS];
   logic [START_W-1:0]  lvl_start [TREE_LEVELS+1];
   logic [LVL_W-1:0]    lvl_count;

   relative_type        pending_relatives [$];
   relative_type        head_rel;
   plan_row_type        plan [$];
   int unsigned         n_fail = 0;
   int unsigned         idle_cycles = 0;

   kary_reduction_tree_index u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_node_id    (req_node_id),
      .rsp_strobe     (rsp_strobe),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status),
      .rsp_node_level (rsp_node_level),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(PERIOD/2) clock = ~clock;

   function automatic int unsigned fan_eff();
      int unsigned f;
      f = 32'(cfg_fan);
      if (f < 2) f = 2;
      if (f > FAN_LIMIT) f = FAN_LIMIT;
      return f;
   endfunction

   function automatic void rebuild_levels();
      int unsigned leaves;
      int unsigned f;
      int unsigned n;
      int unsigned size;
      bit          done;
      leaves = 32'(cfg_leaf);
      if (leaves < 1) leaves = 1;
      if (leaves > 32'(LEAF_MAX)) leaves = 32'(LEAF_MAX);
      f = fan_eff();
      for (int i = 0; i < TREE_LEVELS; i++) lvl_size[i] = '0;
      for (int i = 0; i <= TREE_LEVELS; i++) lvl_start[i] = '0;
      size = leaves;
      n = 0;
      do begin
         lvl_size[n] = ID_W'(size);
         lvl_start[n+1] = lvl_start[n] + START_W'(size);
         n++;
         done = (size <= 1) || (n >= TREE_LEVELS);
         if (!done) size = (size + f - 1) / f;
      end while (!done);
      lvl_count = LVL_W'(n);
   endfunction

   function automatic void push_rel(input int unsigned id, input logic [1:0] status,
                                    input int unsigned level, input bit last);
      relative_type r;
      r.id = ID_W'(id);
      r.status = status;
      r.level = LVL_W'(level);
      r.last = last;
      pending_relatives.insert(pending_relatives.size(), r);
   endfunction

   function automatic void predict_relatives(input logic kind, input logic [ID_W-1:0] node);
      int unsigned f;
      int unsigned lvl;
      int unsigned k;
      int unsigned lo;
      int unsigned hi;
      f = fan_eff();
      lvl = 0;
      if (32'(node) >= 32'(lvl_start[lvl_count])) begin
         push_rel(0, STATUS_RANGE, 0, 1'b1);
         return;
      end
      while (lvl + 1 < 32'(lvl_count) && 32'(node) >= 32'(lvl_start[lvl+1])) lvl++;
      k = 32'(node) - 32'(lvl_start[lvl]);
      if (kind == KIND_PARENT) begin
         if (lvl + 1 >= 32'(lvl_count)) push_rel(0, STATUS_NONE, lvl, 1'b1);
         else push_rel(32'(lvl_start[lvl+1]) + k / f, STATUS_VALID, lvl, 1'b1);
      end else if (lvl == 0) begin
         push_rel(0, STATUS_NONE, lvl, 1'b1);
      end else begin
         lo = k * f;
         hi = lo + f;
         if (hi > 32'(lvl_size[lvl-1])) hi = 32'(lvl_size[lvl-1]);
         if (lo >= hi) push_rel(0, STATUS_NONE, lvl, 1'b1);
         for (int unsigned i = lo; i < hi; i++) begin
            push_rel(32'(lvl_start[lvl-1]) + i, STATUS_VALID, lvl, (i + 1 == hi));
         end
      end
   endfunction

   function automatic void add_row(input row_op_type op, input logic kind,
                                   input logic [ID_W-1:0] value, input bit typed,
                                   input logic [1:0] status, input int unsigned level);
      plan_row_type r;
      r.op = op;
      r.kind = kind;
      r.value = value;
      r.typed = typed;
      r.status = status;
      r.level = LVL_W'(level);
      plan.insert(plan.size(), r);
   endfunction

   function automatic int unsigned gap_len(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic [ID_W-1:0] pick_node();
      int unsigned total;
      int unsigned l;
      total = 32'(lvl_start[lvl_count]);
      l = $urandom_range(0, 32'(lvl_count) - 1);
      case ($urandom_range(0, 9))
         0: return ID_W'($urandom);
         1: return ID_W'(total + $urandom_range(0, 3));
         2: return ID_W'(lvl_start[l]);
         3: return ID_W'(lvl_start[l+1] - START_W'(1));
         default: return ID_W'($urandom_range(0, total - 1));
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_leaf();
      case ($urandom_range(0, 7))
         0: return ID_W'($urandom);
         1: return ID_W'(32'(LEAF_MAX) - $urandom_range(0, 1));
         2: return ID_W'($urandom_range(0, 1));
         3: return ID_W'($urandom_range(300, 5000));
         default: return ID_W'($urandom_range(1, 200));
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_fan();
      case ($urandom_range(0, 7))
         0: return ID_W'($urandom);
         1: return ID_W'($urandom_range(0, 1));
         2: return ID_W'($urandom_range(63, 64));
         3: return ID_W'($urandom_range(65, 127));
         default: return ID_W'($urandom_range(2, 16));
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         n_fail++;
      end
   endfunction

   task automatic send_query(input logic kind, input logic [ID_W-1:0] node);
      start <= 1'b1;
      req_kind <= kind;
      req_node_id <= node;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int unsigned n);
      if (n > 0) begin
         start <= 1'b0;
         req_kind <= 1'($urandom);
         req_node_id <= ID_W'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_relatives.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [ID_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_wdata <= ID_W'($urandom);
      if (idx == CSR_LEAF_COUNT) cfg_leaf = data;
      else cfg_fan = data[FAN_W-1:0];
      rebuild_levels();
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_relatives.size() == 0) begin
            $display("%0t: unexpected result id %0d status %0d level %0d last %0d",
                     $time, rsp_result_id, rsp_status, rsp_node_level, rsp_last);
            n_fail++;
         end else begin
            head_rel = pending_relatives.pop_front();
            check_field("result_id", 32'(head_rel.id), 32'(rsp_result_id));
            check_field("status", 32'(head_rel.status), 32'(rsp_status));
            check_field("node_level", 32'(head_rel.level), 32'(rsp_node_level));
            check_field("last", 32'(head_rel.last), 32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("kary_reduction_tree_index: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      plan_row_type row;
      bit          quiet;
      logic        kind;
      logic [ID_W-1:0] node;

      cfg_leaf = 1;
      cfg_fan = 2;
      rebuild_levels();

      add_row(ROW_QUERY, KIND_PARENT,   0,          1, STATUS_NONE,  0);
      add_row(ROW_QUERY, KIND_CHILDREN, 0,          1, STATUS_NONE,  0);
      add_row(ROW_QUERY, KIND_PARENT,   1,          1, STATUS_RANGE, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 21'h1FFFFF, 1, STATUS_RANGE, 0);
      add_row(ROW_LEAF,  KIND_PARENT,   10,         0, STATUS_VALID, 0);
      add_row(ROW_FAN,   KIND_PARENT,   3,          0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   0,          0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   9,          0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 10,         0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 13,         0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   16,         1, STATUS_NONE,  3);
      add_row(ROW_QUERY, KIND_CHILDREN, 16,         0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 5,          1, STATUS_NONE,  0);
      add_row(ROW_QUERY, KIND_PARENT,   17,         1, STATUS_RANGE, 0);
      add_row(ROW_FAN,   KIND_PARENT,   64,         0, STATUS_VALID, 0);
      add_row(ROW_LEAF,  KIND_PARENT,   LEAF_MAX,   0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 1114368,    0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   1048575,    0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 1048576,    0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   21'h1FFFFF, 1, STATUS_RANGE, 0);
      add_row(ROW_FAN,   KIND_PARENT,   0,          0, STATUS_VALID, 0);
      add_row(ROW_LEAF,  KIND_PARENT,   21'h1FFFFF, 0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   2097150,    1, STATUS_NONE,  20);
      add_row(ROW_QUERY, KIND_CHILDREN, 2097150,    0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 21'h1FFFFF, 1, STATUS_RANGE, 0);
      add_row(ROW_QUERY, KIND_PARENT,   0,          0, STATUS_VALID, 0);
      add_row(ROW_FAN,   KIND_PARENT,   21'h1FFFFF, 0, STATUS_VALID, 0);
      add_row(ROW_LEAF,  KIND_PARENT,   0,          0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 0,          1, STATUS_NONE,  0);
      add_row(ROW_QUERY, KIND_PARENT,   0,          1, STATUS_NONE,  0);
      add_row(ROW_FAN,   KIND_PARENT,   1,          0, STATUS_VALID, 0);
      add_row(ROW_LEAF,  KIND_PARENT,   2,          0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_CHILDREN, 2,          0, STATUS_VALID, 0);
      add_row(ROW_QUERY, KIND_PARENT,   1,          0, STATUS_VALID, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.op == ROW_QUERY) begin
            send_query(row.kind, row.value);
            if (row.typed) push_rel(0, row.status, 32'(row.level), 1'b1);
            else predict_relatives(row.kind, row.value);
            idle_for(gap_len(1'b0));
         end else begin
            drain();
            write_reg((row.op == ROW_LEAF) ? CSR_LEAF_COUNT : CSR_FAN_IN, row.value);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_LEAF_COUNT, pick_leaf());
            write_reg(CSR_FAN_IN, pick_fan());
         end else begin
            write_reg(CSR_FAN_IN, pick_fan());
            write_reg(CSR_LEAF_COUNT, pick_leaf());
         end
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = 1'($urandom);
            node = pick_node();
            send_query(kind, node);
            predict_relatives(kind, node);
            if ($urandom_range(0, 19) == 0) drain();
            else idle_for(gap_len(quiet));
         end
      end

      drain();
      repeat (END_WAIT) @(posedge clock);
      if (n_fail == 0) begin
         $display("kary_reduction_tree_index: match");
      end else begin
         $display("kary_reduction_tree_index: mismatch");
      end
      $finish;
   end

endmodule
